// ----- hdl/odq_pkg.sv -----
// ----------------------------------------------------------------------------
// odq_pkg
// Types, constants and helper functions for the ordered dither quantiser.
// ----------------------------------------------------------------------------
`default_nettype none

package odq_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned NUM_CH         = 4;
  localparam int unsigned DIV_STAGES     = 4;
  localparam int unsigned ADDR_W         = 4;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_LEVELS = 2'd0,
    REG_MASK   = 2'd1,
    REG_ORDER  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ORD_2X2 = 2'd0,
    ORD_4X4 = 2'd1,
    ORD_8X8 = 2'd2
  } order_t;

  typedef logic [7:0] byte_t;

  function automatic logic [5:0] rank2(input logic [1:0] idx);
    logic [5:0] r;
    case (idx)
      2'd0: r = 6'd0;
      2'd1: r = 6'd2;
      2'd2: r = 6'd3;
      default: r = 6'd1;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] rank4(input logic [3:0] idx);
    logic [5:0] r;
    case (idx)
      4'd0: r = 6'd0;   4'd1: r = 6'd8;   4'd2: r = 6'd2;   4'd3: r = 6'd10;
      4'd4: r = 6'd12;  4'd5: r = 6'd4;   4'd6: r = 6'd14;  4'd7: r = 6'd6;
      4'd8: r = 6'd3;   4'd9: r = 6'd11;  4'd10: r = 6'd1;  4'd11: r = 6'd9;
      4'd12: r = 6'd15; 4'd13: r = 6'd7;  4'd14: r = 6'd13;
      default: r = 6'd5;
    endcase
    return r;
  endfunction

  // The 8x8 matrix is built from the 4x4 one recursively:
  // M8(x,y) = 4*M4(x&3,y&3) + M2(x>>2,y>>2).
  function automatic logic [5:0] rank8(input logic [2:0] x, input logic [2:0] y);
    logic [5:0] hi;
    logic [5:0] lo;
    hi = rank4({y[1:0], x[1:0]});
    lo = rank2({y[2], x[2]});
    return {hi[3:0], 2'b00} + lo;
  endfunction

  // One restoring division step: upper byte is the partial remainder,
  // lower byte holds unused dividend bits with quotient bits shifted in.
  function automatic logic [15:0] div_step(input logic [15:0] w, input logic [7:0] d);
    logic [8:0] t;
    logic [7:0] r;
    logic       q;
    t = {w[15:8], w[7]};
    if (t >= {1'b0, d}) begin
      r = 8'(t - {1'b0, d});
      q = 1'b1;
    end else begin
      r = t[7:0];
      q = 1'b0;
    end
    return {r, w[6:0], q};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ordered_dither_quantizer_core.sv -----
// ----------------------------------------------------------------------------
// ordered_dither_quantizer_core
// Bayer ordered dither and requantisation of one RGBA8 pixel per clock.
// ----------------------------------------------------------------------------
//  channel  | ports                         | handshake
//  input    | in_x_pos .. in_alpha_in       | start && !busy
//  result   | out_red_out .. out_alpha_out  | out_valid, one cycle
//  config   | psel penable pwrite paddr ... | APB, pready tied high
//
// One pixel is accepted every clock; busy is never raised.
// Each accepted transaction passes one stage for threshold and products,
// one for the scaled index, and four for the two-bit-per-stage divider
// that forms the output level.
// rst_n is synchronous; it clears the valid bits and sets the configuration registers to their defaults.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_dither_quantizer_core
  import odq_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] in_x_pos,
  input  wire logic [COORD_BITS-1:0] in_y_pos,
  input  wire logic [7:0]            in_red_in,
  input  wire logic [7:0]            in_green_in,
  input  wire logic [7:0]            in_blue_in,
  input  wire logic [7:0]            in_alpha_in,
  output logic                       out_valid,
  output logic [7:0]                 out_red_out,
  output logic [7:0]                 out_green_out,
  output logic [7:0]                 out_blue_out,
  output logic [7:0]                 out_alpha_out,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [8:0] levels_r;
  logic [3:0] mask_r;
  logic [1:0] order_r;
  logic [1:0] reg_sel;
  logic       accept;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= 9'd2;
      mask_r   <= 4'hF;
      order_r  <= 2'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_LEVELS: levels_r <= pwdata[8:0];
        REG_MASK:   mask_r   <= pwdata[3:0];
        REG_ORDER:  order_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LEVELS: prdata = {23'd0, levels_r};
      REG_MASK:   prdata = {28'd0, mask_r};
      REG_ORDER:  prdata = {30'd0, order_r};
      default:    prdata = 32'd0;
    endcase
  end

  // Stage 1: threshold, clamped divisor and channel products.
  logic [2:0]  xl, yl;
  logic [5:0]  rank;
  logic [14:0] tnum;
  logic [7:0]  thr;
  logic [7:0]  m;
  byte_t       vin [NUM_CH];

  assign xl = in_x_pos[2:0];
  assign yl = in_y_pos[2:0];
  assign vin[0] = in_red_in;
  assign vin[1] = in_green_in;
  assign vin[2] = in_blue_in;
  assign vin[3] = in_alpha_in;

  always_comb begin
    case (order_r)
      ORD_2X2: rank = rank2({yl[0], xl[0]});
      ORD_4X4: rank = rank4({yl[1:0], xl[1:0]});
      default: rank = rank8(xl, yl);
    endcase
    tnum = 15'({rank, 1'b1}) * 15'd255;
    case (order_r)
      ORD_2X2: thr = 8'(tnum >> 3);
      ORD_4X4: thr = 8'(tnum >> 5);
      default: thr = 8'(tnum >> 7);
    endcase
    if (levels_r < 9'd2)        m = 8'd1;
    else if (levels_r > 9'd256) m = 8'd255;
    else                        m = 8'(levels_r - 9'd1);
  end

  logic        s1_vld_r;
  logic [7:0]  s1_thr_r, s1_m_r;
  logic [3:0]  s1_mask_r;
  logic [15:0] s1_prod_r [NUM_CH];
  byte_t       s1_v_r    [NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= accept;
  end

  always_ff @(posedge clk) begin
    s1_thr_r  <= thr;
    s1_m_r    <= m;
    s1_mask_r <= mask_r;
    for (int c = 0; c < NUM_CH; c++) begin
      s1_v_r[c]    <= vin[c];
      s1_prod_r[c] <= 16'(vin[c]) * 16'(m);
    end
  end

  // Stage 2: divide by 255, dither step, form the level dividend.
  logic [15:0] num [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      logic [16:0] qs;
      logic [7:0]  q;
      logic [7:0]  rm;
      qs = 17'(s1_prod_r[c]) + 17'(s1_prod_r[c] >> 8) + 17'd1;
      q  = qs[15:8];
      rm = 8'(s1_prod_r[c] - {q, 8'd0} + 16'(q));
      if (rm > s1_thr_r && q < s1_m_r) q = q + 8'd1;
      num[c] = {q, 8'd0} - 16'(q) + 16'(s1_m_r >> 1);
    end
  end

  logic        s2_vld_r;
  logic [7:0]  s2_m_r;
  logic [3:0]  s2_mask_r;
  logic [15:0] s2_num_r [NUM_CH];
  byte_t       s2_v_r   [NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_m_r    <= s1_m_r;
    s2_mask_r <= s1_mask_r;
    for (int c = 0; c < NUM_CH; c++) begin
      s2_num_r[c] <= num[c];
      s2_v_r[c]   <= s1_v_r[c];
    end
  end

  // Divider stages: two quotient bits per stage. The quotient stays below
  // 256, so the top byte of the dividend is already smaller than m.
  logic        d_vld_r  [DIV_STAGES];
  logic [7:0]  d_m_r    [DIV_STAGES];
  logic [3:0]  d_mask_r [DIV_STAGES];
  logic [15:0] d_w_r    [DIV_STAGES][NUM_CH];
  byte_t       d_v_r    [DIV_STAGES][NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) d_vld_r[s] <= 1'b0;
    end else begin
      d_vld_r[0] <= s2_vld_r;
      for (int s = 1; s < DIV_STAGES; s++) d_vld_r[s] <= d_vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    d_m_r[0]    <= s2_m_r;
    d_mask_r[0] <= s2_mask_r;
    for (int c = 0; c < NUM_CH; c++) begin
      d_w_r[0][c] <= div_step(div_step(s2_num_r[c], s2_m_r), s2_m_r);
      d_v_r[0][c] <= s2_v_r[c];
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      d_m_r[s]    <= d_m_r[s-1];
      d_mask_r[s] <= d_mask_r[s-1];
      for (int c = 0; c < NUM_CH; c++) begin
        d_w_r[s][c] <= div_step(div_step(d_w_r[s-1][c], d_m_r[s-1]), d_m_r[s-1]);
        d_v_r[s][c] <= d_v_r[s-1][c];
      end
    end
  end

  localparam int unsigned LAST = DIV_STAGES - 1;

  assign out_valid     = d_vld_r[LAST];
  assign out_red_out   = d_mask_r[LAST][0] ? d_w_r[LAST][0][7:0] : d_v_r[LAST][0];
  assign out_green_out = d_mask_r[LAST][1] ? d_w_r[LAST][1][7:0] : d_v_r[LAST][1];
  assign out_blue_out  = d_mask_r[LAST][2] ? d_w_r[LAST][2][7:0] : d_v_r[LAST][2];
  assign out_alpha_out = d_mask_r[LAST][3] ? d_w_r[LAST][3][7:0] : d_v_r[LAST][3];

  // Every accepted transaction leaves the pipeline as a valid result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_valid)
    else $error("accepted transaction did not emerge after six cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 6))
    else $error("result without a matching transaction");

  a_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (s2_num_r[0][15:8] < s2_m_r))
    else $error("divider dividend out of range");

endmodule

`default_nettype wire

// ----- tb/ordered_dither_quantizer_core_checker.sv -----
// ----------------------------------------------------------------------------
// ordered_dither_quantizer_core_checker
// Watches the pixel and result channels and the register port, predicts each
// dithered pixel and compares it, field by field, with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ordered_dither_quantizer_core_checker
  import odq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [15:0] in_x_pos,
  input  wire logic [15:0] in_y_pos,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  input  wire logic [7:0]  in_alpha_in,
  input  wire logic        out_valid,
  input  wire logic [7:0]  out_red_out,
  input  wire logic [7:0]  out_green_out,
  input  wire logic [7:0]  out_blue_out,
  input  wire logic [7:0]  out_alpha_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending_pixels
);

  typedef struct packed {
    byte_t r;
    byte_t g;
    byte_t b;
    byte_t a;
  } rgba_t;

  localparam byte_t BAYER2[4]  = '{0, 2, 3, 1};
  localparam byte_t BAYER4[16] = '{0, 8, 2, 10, 12, 4, 14, 6, 3, 11, 1, 9, 15, 7, 13, 5};
  localparam byte_t BAYER8[64] = '{
    0, 32, 8, 40, 2, 34, 10, 42, 48, 16, 56, 24, 50, 18, 58, 26,
    12, 44, 4, 36, 14, 46, 6, 38, 60, 28, 52, 20, 62, 30, 54, 22,
    3, 35, 11, 43, 1, 33, 9, 41, 51, 19, 59, 27, 49, 17, 57, 25,
    15, 47, 7, 39, 13, 45, 5, 37, 63, 31, 55, 23, 61, 29, 53, 21};

  logic [8:0] levels_q;
  logic [3:0] mask_q;
  logic [1:0] order_q;
  rgba_t      expected_pixels[$];

  function automatic byte_t quantise(byte_t v, int unsigned m, int unsigned thr);
    int unsigned scaled;
    int unsigned idx;
    scaled = v * m;
    idx = scaled / 255;
    if (scaled % 255 > thr && idx < m) idx++;
    return byte_t'((idx * 255 + m / 2) / m);
  endfunction

  function automatic rgba_t dither_pixel(logic [15:0] x, logic [15:0] y, rgba_t px);
    int unsigned ord;
    int unsigned n;
    int unsigned lv;
    int unsigned rank;
    int unsigned thr;
    byte_t ch[4];
    rgba_t res;
    ord = (order_q > ORD_8X8) ? 2 : order_q;
    n = 2 << ord;
    lv = levels_q;
    if (lv < 2) lv = 2;
    if (lv > 256) lv = 256;
    case (ord)
      0: rank = BAYER2[{y[0], x[0]}];
      1: rank = BAYER4[{y[1:0], x[1:0]}];
      default: rank = BAYER8[{y[2:0], x[2:0]}];
    endcase
    thr = ((rank * 2 + 1) * 255) / (n * n * 2);
    ch = '{px.r, px.g, px.b, px.a};
    for (int c = 0; c < 4; c++) begin
      if (mask_q[c]) ch[c] = quantise(ch[c], lv - 1, thr);
    end
    res = '{ch[0], ch[1], ch[2], ch[3]};
    return res;
  endfunction

  task automatic report_mismatch(string what, byte_t got, byte_t want);
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial pending_pixels = 0;

  always @(posedge clk) begin
    rgba_t want;
    if (!rst_n) begin
      levels_q <= 9'd2;
      mask_q <= 4'hf;
      order_q <= ORD_2X2;
      expected_pixels.delete();
      pending_pixels <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_LEVELS: levels_q <= pwdata[8:0];
          REG_MASK:   mask_q <= pwdata[3:0];
          REG_ORDER:  order_q <= pwdata[1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with no pixel outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_red_out !== want.r) report_mismatch("red", out_red_out, want.r);
          if (out_green_out !== want.g) report_mismatch("green", out_green_out, want.g);
          if (out_blue_out !== want.b) report_mismatch("blue", out_blue_out, want.b);
          if (out_alpha_out !== want.a) report_mismatch("alpha", out_alpha_out, want.a);
        end
      end
      if (start && !busy)
        expected_pixels.push_back(dither_pixel(in_x_pos, in_y_pos,
            '{in_red_in, in_green_in, in_blue_in, in_alpha_in}));
      pending_pixels <= expected_pixels.size();
    end
  end

  initial fail_count = 0;

endmodule

// ----- tb/ordered_dither_quantizer_core_test.sv -----
// ----------------------------------------------------------------------------
// ordered_dither_quantizer_core_test
// Drives pixels and register writes into the dither quantiser through several
// register settings, with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ordered_dither_quantizer_core_test;
  import odq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_x_pos = '0;
  logic [15:0] in_y_pos = '0;
  logic [7:0] in_red_in = '0;
  logic [7:0] in_green_in = '0;
  logic [7:0] in_blue_in = '0;
  logic [7:0] in_alpha_in = '0;
  logic out_valid;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic [7:0] out_alpha_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count;
  int pending_pixels;
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ordered_dither_quantizer_core dut (.*);

  ordered_dither_quantizer_core_checker checker_i (.*);

  // Any cycle without a pixel, result or register write counts towards timeout.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[ordered_dither_quantizer_core] ERROR");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_gap();
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    repeat (gap) @(posedge clk);
  endtask

  // Drives one pixel; start stays high across back-to-back pixels.
  task automatic send_pixel(logic [15:0] x, logic [15:0] y, byte_t r, byte_t g,
                            byte_t b, byte_t a, bit gaps);
    start <= 1'b1;
    in_x_pos <= x;
    in_y_pos <= y;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_alpha_in <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      random_gap();
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_pixels != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(int count, bit calm);
    for (int i = 0; i < count; i++)
      send_pixel(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), !calm);
  endtask

  initial begin
    logic [31:0] lv_set[10];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, then extremes of every field.
    send_pixel(16'h0000, 16'h0000, 8'h00, 8'hff, 8'h80, 8'h7f, 1'b0);
    send_pixel(16'hffff, 16'hffff, 8'hff, 8'h00, 8'h01, 8'hfe, 1'b0);
    send_pixel(16'h0001, 16'h0000, 8'h55, 8'haa, 8'h33, 8'hcc, 1'b0);
    send_pixel(16'h0000, 16'h0001, 8'h80, 8'h80, 8'h80, 8'h80, 1'b0);
    drain();

    // Levels below and above range, order three, empty mask.
    write_reg(REG_LEVELS, 32'd0);
    write_reg(REG_ORDER, 32'd3);
    send_pixel(16'h0007, 16'h0005, 8'h90, 8'h40, 8'h20, 8'hf0, 1'b0);
    drain();
    write_reg(REG_LEVELS, 32'd1);
    send_pixel(16'h0003, 16'h0006, 8'h70, 8'h10, 8'he0, 8'h08, 1'b0);
    drain();
    write_reg(REG_LEVELS, 32'h1ff);
    write_reg(REG_MASK, 32'd0);
    send_pixel(16'haaaa, 16'h5555, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
    drain();
    write_reg(REG_LEVELS, 32'd257);
    write_reg(REG_MASK, 32'hf);
    write_reg(REG_ORDER, 32'(ORD_4X4));
    for (int i = 0; i < 8; i++)
      send_pixel(16'(i), 16'(i * 3), 8'(i * 37), 8'(255 - i), 8'(i * 91), 8'(i), 1'b0);
    drain();

    lv_set = '{2, 3, 4, 7, 16, 100, 255, 256, 0, 511};
    for (int phase = 0; phase < 24; phase++) begin
      write_reg(REG_LEVELS, (phase < 10) ? lv_set[phase] : $urandom_range(0, 511));
      write_reg(REG_MASK, (phase % 7 == 0) ? 32'd0 : $urandom_range(1, 15));
      write_reg(REG_ORDER, 32'(phase % 4));
      // Some phases run without any gaps at full rate.
      send_random(80, phase % 3 == 0);
      drain();
    end

    if (fail_count == 0) $display("[ordered_dither_quantizer_core] OK");
    else $display("[ordered_dither_quantizer_core] ERROR");
    $finish;
  end

endmodule
